>>> sv/ipc_pkg.sv
// shared types, constants and decode helpers for the intcode processor core
// no dependencies; imported by ipc_ctrl, ipc_datapath and intcode_processor_core
package ipc_pkg;

    localparam int MEM_WORDS  = 4096;
    localparam int ADDR_BITS  = $clog2(MEM_WORDS);
    localparam int WORD_BITS  = 64;
    localparam int HALF_BITS  = WORD_BITS / 2;
    localparam int DIV_STEPS  = WORD_BITS / 8;
    localparam int DCNT_BITS  = $clog2(DIV_STEPS);

    // reciprocal constants for the decimal digit split
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    localparam logic [7:0]  RECIP_10   = 8'd205;
    localparam int          RECIP_10_SH = 11;
    localparam logic [WORD_BITS-1:0] DEC_LIMIT = WORD_BITS'(100000);

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_EXEC   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [6:0] OP_ADD  = 7'd1;
    localparam logic [6:0] OP_MUL  = 7'd2;
    localparam logic [6:0] OP_IN   = 7'd3;
    localparam logic [6:0] OP_OUT  = 7'd4;
    localparam logic [6:0] OP_JT   = 7'd5;
    localparam logic [6:0] OP_JF   = 7'd6;
    localparam logic [6:0] OP_LT   = 7'd7;
    localparam logic [6:0] OP_EQ   = 7'd8;
    localparam logic [6:0] OP_ADJ  = 7'd9;
    localparam logic [6:0] OP_HALT = 7'd99;
    localparam logic [6:0] OP_NONE = 7'd0;

    localparam logic [3:0] MODE_POS = 4'd0;
    localparam logic [3:0] MODE_IMM = 4'd1;
    localparam logic [3:0] MODE_REL = 4'd2;

    localparam logic [1:0] SLOT_NONE = 2'd3;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_OUT      = 3'd1,
        ST_WAIT     = 3'd2,
        ST_HALT     = 3'd3,
        ST_BAD_OP   = 3'd4,
        ST_BAD_MODE = 3'd5,
        ST_RANGE    = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_READ, S_RDATA, S_FETCH, S_INS, S_DIV,
        S_DEC1, S_DEC2, S_CHECK, S_OPR, S_OPW, S_OPV, S_MUL, S_EXEC, S_FIN
    } t_state;

    typedef struct packed {
        logic    load_req;
        logic    clr_step;
        logic    mem_wr;
        logic    mem_rd;
        logic    val_rd;
        logic    ins_rd;
        logic    ins_load;
        logic    div_step;
        logic    dec1;
        logic    dec2;
        logic    opr_rd;
        logic    opr_imm;
        logic    opr_dest;
        logic    opr_ea_rd;
        logic    opr_val;
        logic    mul_step;
        logic    exec;
        logic    set_code;
        t_status code;
        logic    fin;
    } t_cmd;

    typedef struct packed {
        logic    clr_last;
        logic    div_last;
        t_status chk;
        logic    pc_range;
        logic    opr_is_imm;
        logic    opr_is_dest;
        logic    ea_fault;
        logic    opr_last;
        logic    is_mul;
        logic    mul_last;
        logic    jump_fault;
        logic    out_free;
    } t_sts;

    function automatic logic [1:0] op_count(input logic [6:0] op);
        logic [1:0] n;
        unique case (op)
            OP_ADD, OP_MUL, OP_LT, OP_EQ: n = 2'd3;
            OP_JT, OP_JF:                 n = 2'd2;
            OP_IN, OP_OUT, OP_ADJ:        n = 2'd1;
            default:                      n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] write_slot(input logic [6:0] op);
        logic [1:0] s;
        unique case (op)
            OP_IN:                        s = 2'd0;
            OP_ADD, OP_MUL, OP_LT, OP_EQ: s = 2'd2;
            default:                      s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

>>> sv/ipc_datapath.sv
// datapath of the intcode processor core: word memory, pc, relative base,
// digit split unit, operand registers, shared multiplier and result register
// depends on ipc_pkg
module ipc_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ipc_pkg::t_cmd                   i_cmd,
    output ipc_pkg::t_sts                   o_sts,
    input  logic [ipc_pkg::ADDR_BITS-1:0]   i_mem_addr,
    input  logic signed [ipc_pkg::WORD_BITS-1:0] i_mem_data,
    input  logic signed [ipc_pkg::WORD_BITS-1:0] i_in_value,
    input  logic                            i_in_present,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_status,
    output logic signed [ipc_pkg::WORD_BITS-1:0] o_result_value,
    output logic [ipc_pkg::ADDR_BITS-1:0]   o_prog_counter
);
    import ipc_pkg::*;

    logic [WORD_BITS-1:0] mem [MEM_WORDS];

    logic [ADDR_BITS-1:0] r_addr, r_pc, r_dest, r_clr, r_out_pc;
    logic [WORD_BITS-1:0] r_wdat, r_inval, r_rb, r_ins, r_v0, r_v1, r_acc, r_rdata;
    logic [WORD_BITS-1:0] r_fval, r_out_val;
    logic                 r_inpres, r_big, r_neg, r_out_valid;
    logic [6:0]           r_rem, r_q10;
    logic [9:0]           r_quo;
    logic [DCNT_BITS-1:0] r_dcnt;
    logic [3:0]           r_m0, r_m1, r_m2;
    logic [1:0]           r_i, r_mcnt;
    t_status              r_code, r_out_status;

    // digit split
    logic [14:0] d_x;
    logic [27:0] d_prod;
    logic [7:0]  d_q;
    logic [6:0]  d_r;
    logic [17:0] d_p10;
    logic [6:0]  d_q10;
    logic [14:0] d_p100;
    logic [3:0]  d_q100;

    // decode and operands
    logic [1:0]           d_n, d_wslot;
    logic [3:0]           d_mode [3];
    logic                 d_bad_mode;
    t_status              d_chk;
    logic [ADDR_BITS:0]   d_oaddr;
    logic [3:0]           d_mode_i;
    logic [WORD_BITS-1:0] d_ea;
    logic [ADDR_BITS-1:0] d_next;

    // multiply and execute
    logic [HALF_BITS-1:0] d_ma, d_mb;
    logic [WORD_BITS-1:0] d_mp;
    logic                 d_exec_we, d_taken;
    logic [WORD_BITS-1:0] d_exec_wd;

    // memory port
    logic                 d_we;
    logic [ADDR_BITS-1:0] d_maddr;
    logic [WORD_BITS-1:0] d_wd;

    assign d_x    = {r_rem, r_ins[WORD_BITS-1 -: 8]};
    assign d_prod = 28'(d_x) * 28'(RECIP_100);
    assign d_q    = d_prod[RECIP_100_SH +: 8];
    assign d_r    = 7'(d_x - 15'({7'd0, d_q} * 15'd100));
    assign d_p10  = 18'(r_quo) * 18'(RECIP_10);
    assign d_q10  = d_p10[RECIP_10_SH +: 7];
    assign d_p100 = 15'(r_q10) * 15'(RECIP_10);
    assign d_q100 = d_p100[RECIP_10_SH +: 4];

    assign d_n     = op_count(r_rem);
    assign d_wslot = write_slot(r_rem);

    always_comb begin
        d_mode[0] = r_m0;
        d_mode[1] = r_m1;
        d_mode[2] = r_m2;
    end

    always_comb begin
        d_bad_mode = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < d_n) begin
                if (d_mode[k] > MODE_REL || (2'(k) == d_wslot && d_mode[k] == MODE_IMM)) begin
                    d_bad_mode = 1'b1;
                end
            end
        end
    end

    always_comb begin
        priority if (r_neg)                              d_chk = ST_BAD_OP;
        else if (r_rem == OP_HALT)                       d_chk = ST_HALT;
        else if (r_rem == OP_NONE || r_rem > OP_ADJ)     d_chk = ST_BAD_OP;
        else if (r_big || d_bad_mode)                    d_chk = ST_BAD_MODE;
        else if (r_rem == OP_IN && !r_inpres)            d_chk = ST_WAIT;
        else                                             d_chk = ST_DONE;
    end

    assign d_oaddr  = {1'b0, r_pc} + (ADDR_BITS+1)'(1) + (ADDR_BITS+1)'(r_i);
    assign d_mode_i = d_mode[r_i];
    assign d_ea     = (d_mode_i == MODE_REL) ? r_rb + r_rdata : r_rdata;
    assign d_next   = r_pc + ADDR_BITS'(1) + ADDR_BITS'(d_n);

    assign d_ma = (r_mcnt == 2'd2) ? r_v0[WORD_BITS-1 -: HALF_BITS] : r_v0[HALF_BITS-1:0];
    assign d_mb = (r_mcnt == 2'd1) ? r_v1[WORD_BITS-1 -: HALF_BITS] : r_v1[HALF_BITS-1:0];
    assign d_mp = {{HALF_BITS{1'b0}}, d_ma} * {{HALF_BITS{1'b0}}, d_mb};

    always_comb begin
        d_exec_we = 1'b0;
        d_exec_wd = '0;
        d_taken   = 1'b0;
        unique case (r_rem)
            OP_ADD: begin d_exec_we = 1'b1; d_exec_wd = r_v0 + r_v1; end
            OP_MUL: begin d_exec_we = 1'b1; d_exec_wd = r_acc; end
            OP_IN:  begin d_exec_we = 1'b1; d_exec_wd = r_inval; end
            OP_LT: begin
                d_exec_we = 1'b1;
                d_exec_wd = {{(WORD_BITS-1){1'b0}}, ($signed(r_v0) < $signed(r_v1))};
            end
            OP_EQ: begin
                d_exec_we = 1'b1;
                d_exec_wd = {{(WORD_BITS-1){1'b0}}, (r_v0 == r_v1)};
            end
            OP_JT:  d_taken = (r_v0 != '0);
            OP_JF:  d_taken = (r_v0 == '0);
            default: ;
        endcase
    end

    always_comb begin
        d_we    = 1'b0;
        d_wd    = '0;
        d_maddr = r_pc;
        priority if (i_cmd.clr_step) begin
            d_we    = 1'b1;
            d_maddr = r_clr;
        end else if (i_cmd.mem_wr) begin
            d_we    = 1'b1;
            d_maddr = r_addr;
            d_wd    = r_wdat;
        end else if (i_cmd.mem_rd) begin
            d_maddr = r_addr;
        end else if (i_cmd.ins_rd) begin
            d_maddr = r_pc;
        end else if (i_cmd.opr_rd) begin
            d_maddr = d_oaddr[ADDR_BITS-1:0];
        end else if (i_cmd.opr_ea_rd) begin
            d_maddr = d_ea[ADDR_BITS-1:0];
        end else if (i_cmd.exec) begin
            d_we    = d_exec_we;
            d_maddr = r_dest;
            d_wd    = d_exec_wd;
        end else begin
            d_maddr = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            mem[d_maddr] <= d_wd;
        end
        r_rdata <= mem[d_maddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_pc        <= '0;
            r_rb        <= '0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_mcnt      <= '0;
            r_dcnt      <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + ADDR_BITS'(1);
            if (i_cmd.ins_load) begin
                r_i    <= '0;
                r_mcnt <= '0;
                r_dcnt <= '0;
            end
            if (i_cmd.div_step) r_dcnt <= r_dcnt + DCNT_BITS'(1);
            if (i_cmd.opr_imm || i_cmd.opr_dest || i_cmd.opr_val) r_i <= r_i + 2'd1;
            if (i_cmd.mul_step) r_mcnt <= r_mcnt + 2'd1;
            if (i_cmd.exec) begin
                r_pc <= d_taken ? r_v1[ADDR_BITS-1:0] : d_next;
                if (r_rem == OP_ADJ) r_rb <= r_rb + r_v0;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_addr   <= i_mem_addr;
            r_wdat   <= i_mem_data;
            r_inval  <= i_in_value;
            r_inpres <= i_in_present;
            r_code   <= ST_DONE;
            r_fval   <= '0;
        end
        if (i_cmd.val_rd) r_fval <= r_rdata;
        if (i_cmd.set_code) r_code <= i_cmd.code;
        if (i_cmd.exec && r_rem == OP_OUT) begin
            r_code <= ST_OUT;
            r_fval <= r_v0;
        end
        if (i_cmd.ins_load) begin
            r_ins <= r_rdata;
            r_rem <= '0;
            r_neg <= r_rdata[WORD_BITS-1];
            r_big <= r_rdata >= DEC_LIMIT;
        end
        if (i_cmd.div_step) begin
            r_ins <= {r_ins[WORD_BITS-9:0], 8'd0};
            r_rem <= d_r;
            r_quo <= {r_quo[1:0], d_q};
        end
        if (i_cmd.dec1) begin
            r_q10 <= d_q10;
            r_m0  <= 4'(r_quo - 10'({3'd0, d_q10} * 10'd10));
        end
        if (i_cmd.dec2) begin
            r_m1 <= 4'(r_q10 - 7'({3'd0, d_q100} * 7'd10));
            r_m2 <= d_q100;
        end
        if (i_cmd.opr_imm || i_cmd.opr_val) begin
            if (r_i == 2'd0) r_v0 <= r_rdata;
            else             r_v1 <= r_rdata;
        end
        if (i_cmd.opr_dest) r_dest <= d_ea[ADDR_BITS-1:0];
        if (i_cmd.mul_step) begin
            if (r_mcnt == 2'd0) r_acc <= d_mp;
            else                r_acc <= r_acc + {d_mp[HALF_BITS-1:0], {HALF_BITS{1'b0}}};
        end
        if (i_cmd.fin) begin
            r_out_status <= r_code;
            r_out_val    <= r_fval;
            r_out_pc     <= r_pc;
        end
    end

    always_comb begin
        o_sts.clr_last    = &r_clr;
        o_sts.div_last    = (r_dcnt == DCNT_BITS'(DIV_STEPS - 1));
        o_sts.chk         = d_chk;
        o_sts.pc_range    = d_oaddr[ADDR_BITS];
        o_sts.opr_is_imm  = (d_mode_i == MODE_IMM);
        o_sts.opr_is_dest = (r_i == d_wslot);
        o_sts.ea_fault    = (d_ea[WORD_BITS-1:ADDR_BITS] != '0);
        o_sts.opr_last    = ((r_i + 2'd1) == d_n);
        o_sts.is_mul      = (r_rem == OP_MUL);
        o_sts.mul_last    = (r_mcnt == 2'd2);
        o_sts.jump_fault  = d_taken && (r_v1[WORD_BITS-1:ADDR_BITS] != '0);
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_value = r_out_val;
    assign o_prog_counter = r_out_pc;

endmodule

>>> sv/ipc_ctrl.sv
// sequencer of the intcode processor core: clearing pass, request dispatch,
// instruction fetch, decode, operand walk, multiply and commit
// depends on ipc_pkg
module ipc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_req_type,
    output logic          o_in_stall,
    input  ipc_pkg::t_sts i_sts,
    output ipc_pkg::t_cmd o_cmd
);
    import ipc_pkg::*;

    t_state r_state, n_state;
    logic   d_opr_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    assign o_in_stall = (r_state != S_IDLE);

    // operand slot consumed without a memory value read
    assign d_opr_done = i_sts.opr_is_imm || (!i_sts.ea_fault && i_sts.opr_is_dest);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_req_type == REQ_WRITE) n_state = S_WRITE;
                    else if (i_req_type == REQ_READ)     n_state = S_READ;
                    else if (i_req_type == REQ_EXEC)     n_state = S_FETCH;
                    else                                 n_state = S_FIN;
                end
            end
            S_WRITE: n_state = S_FIN;
            S_READ:  n_state = S_RDATA;
            S_RDATA: n_state = S_FIN;
            S_FETCH: n_state = S_INS;
            S_INS:   n_state = S_DIV;
            S_DIV:   if (i_sts.div_last) n_state = S_DEC1;
            S_DEC1:  n_state = S_DEC2;
            S_DEC2:  n_state = S_CHECK;
            S_CHECK: n_state = (i_sts.chk == ST_DONE) ? S_OPR : S_FIN;
            S_OPR:   n_state = i_sts.pc_range ? S_FIN : S_OPW;
            S_OPW: begin
                priority if (d_opr_done) begin
                    if (!i_sts.opr_last)   n_state = S_OPR;
                    else if (i_sts.is_mul) n_state = S_MUL;
                    else                   n_state = S_EXEC;
                end else if (i_sts.ea_fault) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_OPV;
                end
            end
            S_OPV: begin
                if (!i_sts.opr_last)   n_state = S_OPR;
                else if (i_sts.is_mul) n_state = S_MUL;
                else                   n_state = S_EXEC;
            end
            S_MUL:  if (i_sts.mul_last) n_state = S_EXEC;
            S_EXEC: n_state = S_FIN;
            S_FIN:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = ST_DONE;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE:  o_cmd.load_req = i_in_valid;
            S_WRITE: o_cmd.mem_wr   = 1'b1;
            S_READ:  o_cmd.mem_rd   = 1'b1;
            S_RDATA: o_cmd.val_rd   = 1'b1;
            S_FETCH: o_cmd.ins_rd   = 1'b1;
            S_INS:   o_cmd.ins_load = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_DEC1:  o_cmd.dec1     = 1'b1;
            S_DEC2:  o_cmd.dec2     = 1'b1;
            S_CHECK: begin
                o_cmd.set_code = (i_sts.chk != ST_DONE);
                o_cmd.code     = i_sts.chk;
            end
            S_OPR: begin
                if (i_sts.pc_range) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_RANGE;
                end else begin
                    o_cmd.opr_rd = 1'b1;
                end
            end
            S_OPW: begin
                priority if (i_sts.opr_is_imm) begin
                    o_cmd.opr_imm = 1'b1;
                end else if (i_sts.ea_fault) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_RANGE;
                end else if (i_sts.opr_is_dest) begin
                    o_cmd.opr_dest = 1'b1;
                end else begin
                    o_cmd.opr_ea_rd = 1'b1;
                end
            end
            S_OPV:  o_cmd.opr_val  = 1'b1;
            S_MUL:  o_cmd.mul_step = 1'b1;
            S_EXEC: begin
                if (i_sts.jump_fault) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_RANGE;
                end else begin
                    o_cmd.exec = 1'b1;
                end
            end
            S_FIN:  o_cmd.fin = i_sts.out_free;
            default: ;
        endcase
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == S_CLEAR) else $error("reset did not start clearing pass");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state != S_IDLE)
        else $error("accepted item left sequencer idle");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_last) |=> r_state == S_DIV)
        else $error("digit split cut short");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_sts.out_free) |-> (!o_cmd.fin ##1 r_state == S_FIN))
        else $error("result dropped while output busy");

endmodule

>>> sv/intcode_processor_core.sv
// top level of the intcode processor core: sequencer plus datapath
// depends on ipc_pkg, ipc_ctrl and ipc_datapath
//
// one item at a time: after reset the core clears all 4096 words of its
// word memory, one word per cycle, with the input stalled. an execute item
// takes one memory read for the instruction word, a byte-serial split
// into opcode and mode digits, the decode steps S_DEC1 and S_DEC2, a check
// step, the steps S_OPR, S_OPW and, where a value is read, S_OPV for each
// operand on the single memory port, three partial products on the shared
// 32x32 multiplier for mul, a commit step and a step that loads the result
// register. faults (bad opcode, bad mode, waiting input, address out of
// range) end the item early and leave pc, relative base and memory
// untouched. the result register lets the next item be accepted while the
// previous result still waits on the output side.
module intcode_processor_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [ipc_pkg::ADDR_BITS-1:0]   i_mem_addr,
    input  logic signed [ipc_pkg::WORD_BITS-1:0] i_mem_data,
    input  logic signed [ipc_pkg::WORD_BITS-1:0] i_in_value,
    input  logic                            i_in_present,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_status,
    output logic signed [ipc_pkg::WORD_BITS-1:0] o_result_value,
    output logic [ipc_pkg::ADDR_BITS-1:0]   o_prog_counter
);
    import ipc_pkg::*;

    // command and status buses between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    ipc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // memory, registers and result slot
    ipc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_mem_addr     (i_mem_addr),
        .i_mem_data     (i_mem_data),
        .i_in_value     (i_in_value),
        .i_in_present   (i_in_present),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_prog_counter (o_prog_counter)
    );

endmodule
